// ===== rtl/rotenc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder counter package
// Word types, command codes and constants shared by the counter modules.
// ----------------------------------------------------------------------------
package rotenc_pkg;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_SET    = 2'd1,
		CMD_READ   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_MIN_LIMIT = 1'b0,
		REG_MAX_LIMIT = 1'b1
	} reg_idx_t;

	localparam logic signed [15:0] CHANGE_LOW  = -16'sd10;
	localparam logic signed [15:0] CHANGE_HIGH = 16'sd10;

	localparam logic signed [15:0] MIN_LIMIT_RST = 16'sd0;
	localparam logic signed [15:0] MAX_LIMIT_RST = 16'sd255;

	typedef struct packed {
		cmd_t               command;
		logic               level_a;
		logic               level_b;
		logic signed [15:0] new_count;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] count;
		logic signed [15:0] change;
	} out_word_t;

	typedef struct packed {
		logic [1:0]         last_phase;
		logic signed [15:0] count;
		logic signed [15:0] count_at_read;
	} state_t;

	typedef struct packed {
		logic signed [15:0] min_limit;
		logic signed [15:0] max_limit;
	} limits_t;

endpackage

// ===== rtl/rotary_encoder_bounded_counter_top.sv =====
// ----------------------------------------------------------------------------
// Bounded rotary encoder counter
// Quadrature phase counter with wrap or saturation limits, clamped load and
// difference-since-last-read reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one word per sample
//   or command; output channel (out_valid / out_stall / out_data) returns one
//   word for each input word, in order.
//   A word is captured in the input register, then the step logic updates
//   the counter state and loads the result register.
//   Throughput is one word per clock while the receiver does not stall; the
//   state update loop (phase, count, last-read count) is what sets that figure.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; in_stall rises only once both are occupied.
//   The configuration channel (cfg_valid / cfg_ready) writes min_limit
//   (index 0) or max_limit (index 1); it is always ready and should only be
//   written while the counter is idle.
//   Reset clears both registers' valid flags, the counter state to zero and
//   the limits to 0 and 255.
// ----------------------------------------------------------------------------
module rotary_encoder_bounded_counter_top import rotenc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  reg_idx_t           cfg_index,
	input  logic signed [15:0] cfg_data
);

	logic      valid_s1;
	in_word_t  word_s1;
	logic      valid_s2;
	out_word_t result_s2;
	state_t    state_q;
	state_t    state_nxt;
	limits_t   limits_q;
	out_word_t result;
	logic      adv;
	logic      take_in;

	assign cfg_ready = 1'b1;

	// s1 moves on when the result register is free or being emptied
	assign adv      = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in)
			word_s1 <= in_data;
	end

	rotenc_step u_step (
		.word      (word_s1),
		.state     (state_q),
		.limits    (limits_q),
		.state_nxt (state_nxt),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			result_s2 <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.min_limit <= MIN_LIMIT_RST;
			limits_q.max_limit <= MAX_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_LIMIT: limits_q.min_limit <= cfg_data;
				REG_MAX_LIMIT: limits_q.max_limit <= cfg_data;
				default: limits_q <= limits_q;
			endcase
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

// ===== rtl/rotenc_step.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder counter step
// Next-state and result logic for one word: phase decode, bounded step,
// clamped load and corrected read-back difference.
// ----------------------------------------------------------------------------
module rotenc_step import rotenc_pkg::*; (
	input  in_word_t  word,
	input  state_t    state,
	input  limits_t   limits,
	output state_t    state_nxt,
	output out_word_t result
);

	logic [1:0]         phase;
	logic               ccw;
	logic               wrap_mode;
	logic signed [16:0] min17;
	logic signed [16:0] max17;
	logic signed [16:0] up_v;
	logic signed [16:0] dn_v;
	logic signed [15:0] step_v;
	logic signed [15:0] set_v;
	logic signed [15:0] diff0;
	logic signed [15:0] diff1;
	logic signed [15:0] diff2;
	logic signed [15:0] max_p1;

	assign phase     = {word.level_b, word.level_a};
	assign wrap_mode = (limits.min_limit == 16'sd0);
	assign min17     = {limits.min_limit[15], limits.min_limit};
	assign max17     = {limits.max_limit[15], limits.max_limit};

	// counterclockwise: 0->1, 1->3, 3->2, 2->0
	assign ccw = (state.last_phase == 2'd0 && phase == 2'd1)
		|| (state.last_phase == 2'd1 && phase == 2'd3)
		|| (state.last_phase == 2'd3 && phase == 2'd2)
		|| (state.last_phase == 2'd2 && phase == 2'd0);

	// 17-bit step so the limit test sees the exact value
	assign up_v = {state.count[15], state.count} + 17'sd1;
	assign dn_v = {state.count[15], state.count} - 17'sd1;

	always_comb begin
		if (ccw) begin
			if (dn_v < min17)
				step_v = wrap_mode ? limits.max_limit : limits.min_limit;
			else
				step_v = dn_v[15:0];
		end else begin
			if (up_v > max17)
				step_v = wrap_mode ? 16'sd0 : limits.max_limit;
			else
				step_v = up_v[15:0];
		end
	end

	// max wins when the limits are crossed
	always_comb begin
		set_v = word.new_count;
		if (set_v < limits.min_limit)
			set_v = limits.min_limit;
		if (set_v > limits.max_limit)
			set_v = limits.max_limit;
	end

	assign max_p1 = limits.max_limit + 16'sd1;
	assign diff0  = state.count - state.count_at_read;
	assign diff1  = (diff0 < CHANGE_LOW) ? diff0 + max_p1 : diff0;
	assign diff2  = (diff1 > CHANGE_HIGH) ? diff1 - max_p1 : diff1;

	always_comb begin
		state_nxt     = state;
		result.change = 16'sd0;
		case (word.command)
			CMD_SAMPLE: begin
				state_nxt.last_phase = phase;
				if (phase != state.last_phase)
					state_nxt.count = step_v;
			end
			CMD_SET: begin
				state_nxt.count = set_v;
			end
			CMD_READ: begin
				result.change           = diff2;
				state_nxt.count_at_read = state.count;
			end
			default: begin
				state_nxt = state;
			end
		endcase
		result.count = state_nxt.count;
	end

endmodule
